### rtl/qct_pkg.sv
// Package for the quorum commit tracker: widths, event kinds, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package qct_pkg;

	localparam int VER_W        = 63;
	localparam int TAG_W        = 16;
	localparam int KIND_W       = 3;
	localparam int STATUS_W     = 3;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 4;
	localparam int MAX_SERVERS_DEF = 8;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int IN_DATA_W    = 88;  // 3+3+63+16 = 85, padded to bytes
	localparam int OUT_DATA_W   = 88;  // 3+16+63 = 82, padded to bytes

	localparam logic [KIND_W-1:0] KIND_REPORT  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_CURRENT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ADD     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FLUSH   = 3'd4;

	localparam logic [STATUS_W-1:0] ST_ACK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_RETRY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLAVE_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAD_EN      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IN_TERM      = 2'd3;

	localparam int STATE_W = 4;
	localparam logic [STATE_W-1:0] S_IDLE    = 4'd0;
	localparam logic [STATE_W-1:0] S_DISPATCH= 4'd1;
	localparam logic [STATE_W-1:0] S_SCAN    = 4'd2;  // gather eligible slaves
	localparam logic [STATE_W-1:0] S_RANK    = 4'd3;  // rank candidates
	localparam logic [STATE_W-1:0] S_RELEASE = 4'd4;  // check queue head
	localparam logic [STATE_W-1:0] S_POP     = 4'd5;  // shift queue down
	localparam logic [STATE_W-1:0] S_FIND    = 4'd6;  // find insert slot
	localparam logic [STATE_W-1:0] S_SHIFT   = 4'd7;  // shift queue up
	localparam logic [STATE_W-1:0] S_EMIT    = 4'd8;  // result word waiting

	// controller -> datapath
	typedef struct packed {
		logic load;        // latch the accepted word
		logic wr_slave;    // store report into its slot
		logic wr_current;
		logic push;        // raise confirmed to the word's version
		logic scan_start;
		logic scan_step;
		logic rank_start;
		logic rank_step;
		logic rank_commit;
		logic pop_start;
		logic pop_step;
		logic find_start;
		logic find_step;
		logic shift_step;
		logic insert;      // write new entry at slot
		logic emit;        // load result register
		logic [STATUS_W-1:0] emit_status;
		logic emit_head;   // tag from queue head, else request tag / zero
		logic emit_req;    // tag from request
		logic emit_last;
	} qct_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic ver_gt_conf;    // word version > confirmed
		logic queue_empty;
		logic queue_full;
		logic head_ready;     // head version <= confirmed
		logic conf_lt_cur;
		logic scan_done;
		logic quorum_ok;      // eligible + 1 >= majority
		logic majority_one;
		logic rank_done;
		logic pop_done;
		logic find_done;
		logic shift_done;
	} qct_stat_t;

endpackage

### rtl/qct_ctrl.sv
// Controller state machine of the quorum commit tracker.
// Depends on qct_pkg; drives the datapath only through qct_cmd_t.
module qct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             lead_en,
	input  logic             in_term,
	input  logic             out_free,
	output logic             busy,
	input  qct_pkg::qct_stat_t stat,
	output qct_pkg::qct_cmd_t  cmd
);
	import qct_pkg::*;

	logic [STATE_W-1:0] state_q, state_d;
	logic flush_q, flush_d;  // release run is a flush (retry status)

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		flush_d = flush_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				flush_d = 1'b0;
				unique case (stat.kind)
					KIND_REPORT: begin
						cmd.wr_slave = 1'b1;
						if (stat.ver_gt_conf && lead_en) begin
							cmd.scan_start = 1'b1;
							state_d = S_SCAN;
						end else begin
							state_d = S_RELEASE;
						end
					end
					KIND_CURRENT: begin
						cmd.wr_current = 1'b1;
						state_d = S_RELEASE;
						flush_d = 1'b1;  // empty run: straight to ack
					end
					KIND_PUSH: begin
						cmd.push = 1'b1;
						state_d = S_RELEASE;
					end
					KIND_ADD: begin
						if (!stat.ver_gt_conf) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_DONE;
							cmd.emit_req = 1'b1;
							cmd.emit_last = 1'b1;
							state_d = S_EMIT;
						end else if (stat.queue_full) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_FULL;
							cmd.emit_req = 1'b1;
							cmd.emit_last = 1'b1;
							state_d = S_EMIT;
						end else if (!in_term) begin
							cmd.emit = 1'b1;
							cmd.emit_status = ST_RETRY;
							cmd.emit_req = 1'b1;
							cmd.emit_last = 1'b1;
							state_d = S_EMIT;
						end else begin
							cmd.find_start = 1'b1;
							state_d = S_FIND;
						end
					end
					KIND_FLUSH: begin
						flush_d = 1'b1;
						state_d = S_RELEASE;
					end
					default: begin
						flush_d = 1'b1;
						state_d = S_RELEASE;
					end
				endcase
			end
			S_SCAN: begin
				if (stat.scan_done) begin
					if (!stat.quorum_ok) begin
						state_d = S_RELEASE;
					end else begin
						cmd.rank_start = 1'b1;
						state_d = S_RANK;
					end
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_RANK: begin
				if (stat.rank_done) begin
					cmd.rank_commit = 1'b1;
					state_d = S_RELEASE;
				end else begin
					cmd.rank_step = 1'b1;
				end
			end
			S_RELEASE: begin
				// kind 1 and unknown kinds land here with flush_q set but no
				// release allowed: kind 4 releases only when confirmed < current
				if (out_free) begin
					if (!stat.queue_empty &&
					    ((flush_q && stat.kind == KIND_FLUSH && stat.conf_lt_cur) ||
					     (!flush_q && stat.head_ready))) begin
						cmd.emit = 1'b1;
						cmd.emit_status = flush_q ? ST_RETRY : ST_RELEASED;
						cmd.emit_head = 1'b1;
						cmd.pop_start = 1'b1;
						state_d = S_POP;
					end else begin
						cmd.emit = 1'b1;
						cmd.emit_status = ST_ACK;
						cmd.emit_last = 1'b1;
						state_d = S_EMIT;
					end
				end
			end
			S_POP: begin
				if (stat.pop_done) state_d = S_RELEASE;
				else cmd.pop_step = 1'b1;
			end
			S_FIND: begin
				if (stat.find_done) state_d = S_SHIFT;
				else cmd.find_step = 1'b1;
			end
			S_SHIFT: begin
				if (stat.shift_done) begin
					if (out_free) begin
						cmd.insert = 1'b1;
						cmd.emit = 1'b1;
						cmd.emit_status = ST_QUEUED;
						cmd.emit_req = 1'b1;
						cmd.emit_last = 1'b1;
						state_d = S_EMIT;
					end
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			S_EMIT: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			flush_q <= 1'b0;
		end else begin
			state_q <= state_d;
			flush_q <= flush_d;
		end
	end

endmodule

### rtl/qct_dp.sv
// Datapath of the quorum commit tracker: slave slots, versions, wait queue,
// the eligible-slave scan, the ranking unit and the result register.
// Depends on qct_pkg; steered by qct_ctrl through qct_cmd_t.
module qct_dp #(
	parameter int MAX_SERVERS = qct_pkg::MAX_SERVERS_DEF,
	parameter int QUEUE_DEPTH = qct_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [qct_pkg::KIND_W-1:0]    in_kind,
	input  logic [2:0]                    in_slot,
	input  logic [qct_pkg::VER_W-1:0]     in_ver,
	input  logic [qct_pkg::TAG_W-1:0]     in_tag,
	input  logic [3:0]                    server_count,
	input  logic [2:0]                    slave_count,
	input  qct_pkg::qct_cmd_t             cmd,
	output qct_pkg::qct_stat_t            stat,
	input  logic                          out_take,
	output logic                          out_valid,
	output logic [qct_pkg::STATUS_W-1:0]  out_status,
	output logic [qct_pkg::TAG_W-1:0]     out_tag,
	output logic [qct_pkg::VER_W-1:0]     out_conf,
	output logic                          out_last
);
	import qct_pkg::*;

	localparam int SI_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int SC_W = $clog2(MAX_SERVERS + 1);
	localparam int QI_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

	logic [KIND_W-1:0] kind_q;
	logic [VER_W-1:0]  ver_q;
	logic [TAG_W-1:0]  tag_q;
	logic [2:0]        slot_q;

	logic [VER_W-1:0] slave_q [MAX_SERVERS];
	logic [VER_W-1:0] cur_q, conf_q;
	logic [VER_W-1:0] wver_q [QUEUE_DEPTH];
	logic [TAG_W-1:0] wtag_q [QUEUE_DEPTH];
	logic [QC_W-1:0]  wcnt_q;
	logic [QC_W-1:0]  qptr_q;   // pop/find pointer
	logic [QC_W-1:0]  spos_q;   // insert slot
	logic [QC_W-1:0]  sh_q;     // shift cursor, walks down from wcnt

	// eligible slave mask and count
	logic [MAX_SERVERS-1:0] elig_q;
	logic [SC_W-1:0] ecnt_q;
	logic [SC_W-1:0] sidx_q;
	logic [SC_W-1:0] used;
	logic [4:0]      need;
	// ranking: candidate i, best so far
	logic [SC_W-1:0] ridx_q;
	logic [VER_W-1:0] best_q;
	logic [SC_W-1:0] meet_cnt;

	assign need = {2'b0, server_count[3:1]} + 5'd1;
	assign used = (slave_count >= 3'(MAX_SERVERS > 7 ? 7 : MAX_SERVERS)) ?
		SC_W'(MAX_SERVERS > 7 ? 7 : MAX_SERVERS) : SC_W'(slave_count);

	// count eligible slaves that meet the candidate version
	always_comb begin
		meet_cnt = '0;
		for (int i = 0; i < MAX_SERVERS; i++)
			if (elig_q[i] && slave_q[i] >= slave_q[ridx_q[SI_W-1:0]])
				meet_cnt = meet_cnt + SC_W'(1);
	end

	always_comb begin
		stat = '0;
		stat.kind = kind_q;
		stat.ver_gt_conf = ver_q > conf_q;
		stat.queue_empty = (wcnt_q == '0);
		stat.queue_full = (wcnt_q >= QC_W'(QUEUE_DEPTH));
		stat.head_ready = wver_q[0] <= conf_q;
		stat.conf_lt_cur = conf_q < cur_q;
		stat.scan_done = (sidx_q >= used);
		stat.quorum_ok = (5'(ecnt_q) + 5'd1) >= need;
		stat.majority_one = (need <= 5'd1);
		stat.rank_done = (ridx_q >= SC_W'(MAX_SERVERS)) || stat.majority_one;
		// wcnt already holds the reduced count while the queue moves down
		stat.pop_done = (qptr_q >= wcnt_q);
		stat.find_done = (qptr_q >= wcnt_q) || (wver_q[qptr_q[QI_W-1:0]] >= ver_q)
			|| (wver_q[QI_W'(wcnt_q - QC_W'(1))] <= ver_q);
		stat.shift_done = (sh_q <= spos_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			ver_q  <= in_ver;
			tag_q  <= in_tag;
			slot_q <= in_slot;
		end
		if (cmd.rank_start) begin
			ridx_q <= '0;
			best_q <= conf_q;
		end else if (cmd.rank_step) begin
			if (elig_q[ridx_q[SI_W-1:0]] &&
			    5'(meet_cnt) + 5'd1 >= need &&
			    slave_q[ridx_q[SI_W-1:0]] > best_q)
				best_q <= slave_q[ridx_q[SI_W-1:0]];
			ridx_q <= ridx_q + SC_W'(1);
		end
		if (cmd.pop_step) begin
			wver_q[qptr_q[QI_W-1:0]] <= wver_q[QI_W'(qptr_q + QC_W'(1))];
			wtag_q[qptr_q[QI_W-1:0]] <= wtag_q[QI_W'(qptr_q + QC_W'(1))];
		end
		if (cmd.shift_step) begin
			wver_q[sh_q[QI_W-1:0]] <= wver_q[QI_W'(sh_q - QC_W'(1))];
			wtag_q[sh_q[QI_W-1:0]] <= wtag_q[QI_W'(sh_q - QC_W'(1))];
		end
		if (cmd.insert) begin
			wver_q[spos_q[QI_W-1:0]] <= ver_q;
			wtag_q[spos_q[QI_W-1:0]] <= tag_q;
		end
		if (cmd.emit) begin
			out_status <= cmd.emit_status;
			out_tag <= cmd.emit_head ? wtag_q[0] : (cmd.emit_req ? tag_q : '0);
			out_last <= cmd.emit_last;
			out_conf <= conf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SERVERS; i++) slave_q[i] <= '0;
			cur_q <= '0;
			conf_q <= '0;
			wcnt_q <= '0;
			qptr_q <= '0;
			spos_q <= '0;
			sh_q <= '0;
			elig_q <= '0;
			ecnt_q <= '0;
			sidx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.wr_slave && 32'(slot_q) < MAX_SERVERS)
				slave_q[SI_W'(slot_q)] <= ver_q;
			if (cmd.wr_current) cur_q <= ver_q;
			if (cmd.push && ver_q > conf_q) conf_q <= ver_q;
			if (cmd.scan_start) begin
				sidx_q <= '0;
				ecnt_q <= '0;
				elig_q <= '0;
			end else if (cmd.scan_step) begin
				if (slave_q[sidx_q[SI_W-1:0]] > conf_q &&
				    slave_q[sidx_q[SI_W-1:0]] <= cur_q) begin
					elig_q[sidx_q[SI_W-1:0]] <= 1'b1;
					ecnt_q <= ecnt_q + SC_W'(1);
				end
				sidx_q <= sidx_q + SC_W'(1);
			end
			if (cmd.rank_commit) begin
				if (stat.majority_one) begin
					if (cur_q > conf_q) conf_q <= cur_q;
				end else begin
					conf_q <= best_q;
				end
			end
			if (cmd.pop_start) qptr_q <= '0;
			else if (cmd.pop_step) qptr_q <= qptr_q + QC_W'(1);
			if (cmd.pop_start) wcnt_q <= wcnt_q - QC_W'(1);
			if (cmd.find_start) begin
				qptr_q <= '0;
				sh_q <= wcnt_q;
			end else if (cmd.find_step) begin
				qptr_q <= qptr_q + QC_W'(1);
			end
			if (stat.find_done && !cmd.find_start && !cmd.shift_step && !cmd.insert)
				spos_q <= (wcnt_q != '0 && wver_q[QI_W'(wcnt_q - QC_W'(1))] <= ver_q) ?
					wcnt_q : qptr_q;
			if (cmd.shift_step) sh_q <= sh_q - QC_W'(1);
			if (cmd.insert) wcnt_q <= wcnt_q + QC_W'(1);
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_take) out_valid <= 1'b0;
		end
	end

endmodule

### rtl/quorum_commit_tracker.sv
// Top level of the quorum commit tracker: ports, configuration registers,
// and the controller and datapath. Depends on qct_pkg, qct_ctrl, qct_dp.
//
// The block keeps each slave's reported version, the local current version
// and the majority-confirmed version, plus a version-sorted queue of waiting
// requests. One input word is taken at a time (s_tready is low while a word
// is at work). A report on a master scans the slave slots one per cycle and
// then ranks candidates one slot per cycle. Each released request yields one
// result word and then a shift of the remaining queue entries down by one
// place; an insert searches and shifts the queue one entry per cycle. Every
// input word ends with exactly one result word whose tlast is high.
module quorum_commit_tracker #(
	parameter int MAX_SERVERS = qct_pkg::MAX_SERVERS_DEF,
	parameter int QUEUE_DEPTH = qct_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [qct_pkg::CFG_IDX_W-1:0]   cfg_addr,
	input  logic [qct_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// kind[2:0], slave_index[5:3], version[68:6], request_tag[84:69], zero pad
	input  logic [qct_pkg::IN_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// status[2:0], tag_out[18:3], confirmed_out[81:19], zero pad
	output logic [qct_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast
);
	import qct_pkg::*;

	logic [3:0] server_count_q;
	logic [2:0] slave_count_q;
	logic       lead_en_q, in_term_q;
	logic       busy, in_fire, out_take;
	qct_cmd_t   cmd;
	qct_stat_t  stat;
	logic [STATUS_W-1:0] o_status;
	logic [TAG_W-1:0]    o_tag;
	logic [VER_W-1:0]    o_conf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= 4'd3;
			slave_count_q  <= 3'd2;
			lead_en_q      <= 1'b0;
			in_term_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_SERVER_COUNT: server_count_q <= cfg_wdata[3:0];
				REG_SLAVE_COUNT:  slave_count_q  <= cfg_wdata[2:0];
				REG_LEAD_EN:      lead_en_q      <= cfg_wdata[0];
				REG_IN_TERM:      in_term_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// take a word only when idle and the result register has drained
	assign s_tready = !busy && !m_tvalid;
	assign in_fire  = s_tvalid && s_tready;
	assign out_take = m_tvalid && m_tready;

	qct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire),
		.lead_en(lead_en_q), .in_term(in_term_q),
		.out_free(!m_tvalid || m_tready), .busy(busy),
		.stat(stat), .cmd(cmd)
	);

	qct_dp #(.MAX_SERVERS(MAX_SERVERS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.in_kind(s_tdata[2:0]), .in_slot(s_tdata[5:3]),
		.in_ver(s_tdata[68:6]), .in_tag(s_tdata[84:69]),
		.server_count(server_count_q), .slave_count(slave_count_q),
		.cmd(cmd), .stat(stat), .out_take(out_take),
		.out_valid(m_tvalid), .out_status(o_status), .out_tag(o_tag),
		.out_conf(o_conf), .out_last(m_tlast)
	);

	assign m_tdata = {6'd0, o_conf, o_tag, o_status};

	// never accept while a word is in flight
	assert property (@(posedge clk) disable iff (!arst_n) busy |-> !s_tready)
		else $error("input accepted while busy");
	// a result is only produced during work on a word
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(busy))
		else $error("result without a word in progress");
	// once the last word of a run is taken, the output goes quiet
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && m_tready |=> !m_tvalid)
		else $error("extra result after last");

endmodule
